FILE: design/pdtc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdtc_pkg: shared types and constants of the PD torque controller
// Sequencer states, configuration register indexes, reset values and widths.
// ----------------------------------------------------------------------------
package pdtc_pkg;

  // Operand width of the shared multiplier
  localparam int unsigned MUL_W = 32;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_KP_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KD_GAIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_RATE_HZ = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TORQUE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_SIGN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET  = 3'd5;

  // Register reset values
  localparam logic [31:0] KP_GAIN_RESET      = 32'd13107;
  localparam logic [31:0] KD_GAIN_RESET      = 32'd6554;
  localparam logic [15:0] LOOP_RATE_HZ_RESET = 16'd200;
  localparam logic [14:0] MAX_TORQUE_RESET   = 15'd100;

  // Sequencer states, in order of use
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_VEL,
    ST_VERR,
    ST_P_HI,
    ST_P_END,
    ST_D_HI,
    ST_D_END,
    ST_SUM,
    ST_ABS,
    ST_CLAMP,
    ST_OUT
  } state_e;

endpackage : pdtc_pkg
`default_nettype wire

FILE: design/pdtc_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdtc_mul: shared unsigned multiplier
// One registered Width x Width product per cycle, reused by the sequencer.
// ----------------------------------------------------------------------------
module pdtc_mul #(
  parameter int unsigned Width = pdtc_pkg::MUL_W
) (
  input  wire logic                 clk_i,
  input  wire logic [Width-1:0]     a_i,
  input  wire logic [Width-1:0]     b_i,
  output logic      [2*Width-1:0]   p_o
);

  logic [2*Width-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule : pdtc_mul
`default_nettype wire

FILE: design/pd_position_torque_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pd_position_torque_controller: PD servo torque command with saturation
// Position and velocity errors, Q16.16 gains, clamp and rounding per tick.
// ----------------------------------------------------------------------------
// Each input word is one servo tick: desired position, desired velocity and
// measured encoder position. The block answers with one output word holding
// the torque command in permille, rounded half away from zero and clamped to
// +/- max_torque, plus a flag that is set when the clamp cut the value. A
// 12-state sequencer drives one registered 32x32 multiplier five times over
// (velocity scaling, then the low and high halves of each gain product),
// with the adds, magnitudes, clamp and rounding placed in the states
// between. The input side is ready only while the sequencer is idle; the
// result waits in an output register, so the sequencer returns to idle as
// soon as the result is loaded, even if the consumer has not yet taken it,
// and a new word is accepted only once the previous result is loaded. A
// stalled output holds the sequencer in its last state until the pending
// word is taken. The first tick after reset uses the current sample as the
// previous one (zero measured velocity). Configuration writes are always
// ready and take effect at once; write them only while no tick is in flight.
// ----------------------------------------------------------------------------
module pd_position_torque_controller (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration write channel
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [pdtc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [pdtc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // tick input
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic signed [31:0]                 desired_position_i,
  input  wire logic signed [23:0]                 desired_velocity_i,
  input  wire logic signed [31:0]                 measured_position_i,
  // command output
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic signed [15:0]                      torque_command_o,
  output logic                                    saturated_o
);

  localparam int unsigned MW = pdtc_pkg::MUL_W;

  // Combine the two halves of a gain product and saturate the magnitude
  // at 2^62-1.
  function automatic logic [61:0] sat_term(input logic [63:0] lo,
                                           input logic [63:0] hi);
    logic [95:0] full;
    full = {32'd0, lo} + {hi, 32'd0};
    return (|full[95:62]) ? {62{1'b1}} : full[61:0];
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [31:0]        kp_gain_q;
  logic [31:0]        kd_gain_q;
  logic [15:0]        loop_rate_hz_q;
  logic [14:0]        max_torque_q;
  logic               invert_sign_q;
  logic signed [31:0] zero_offset_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_gain_q      <= pdtc_pkg::KP_GAIN_RESET;
      kd_gain_q      <= pdtc_pkg::KD_GAIN_RESET;
      loop_rate_hz_q <= pdtc_pkg::LOOP_RATE_HZ_RESET;
      max_torque_q   <= pdtc_pkg::MAX_TORQUE_RESET;
      invert_sign_q  <= 1'b0;
      zero_offset_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        pdtc_pkg::CFG_KP_GAIN:      kp_gain_q      <= cfg_data_i;
        pdtc_pkg::CFG_KD_GAIN:      kd_gain_q      <= cfg_data_i;
        pdtc_pkg::CFG_LOOP_RATE_HZ: loop_rate_hz_q <= cfg_data_i[15:0];
        pdtc_pkg::CFG_MAX_TORQUE:   max_torque_q   <= cfg_data_i[14:0];
        pdtc_pkg::CFG_INVERT_SIGN:  invert_sign_q  <= cfg_data_i[0];
        pdtc_pkg::CFG_ZERO_OFFSET:  zero_offset_q  <= $signed(cfg_data_i);
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  pdtc_pkg::state_e state_q, state_d;

  logic in_accept;
  logic out_load;

  assign in_ready_o = (state_q == pdtc_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  // Load the result once the output register is free or being emptied
  assign out_load   = (state_q == pdtc_pkg::ST_OUT) && (!out_valid_o || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      pdtc_pkg::ST_IDLE:  if (in_accept) state_d = pdtc_pkg::ST_DIFF;
      pdtc_pkg::ST_DIFF:  state_d = pdtc_pkg::ST_VEL;
      pdtc_pkg::ST_VEL:   state_d = pdtc_pkg::ST_VERR;
      pdtc_pkg::ST_VERR:  state_d = pdtc_pkg::ST_P_HI;
      pdtc_pkg::ST_P_HI:  state_d = pdtc_pkg::ST_P_END;
      pdtc_pkg::ST_P_END: state_d = pdtc_pkg::ST_D_HI;
      pdtc_pkg::ST_D_HI:  state_d = pdtc_pkg::ST_D_END;
      pdtc_pkg::ST_D_END: state_d = pdtc_pkg::ST_SUM;
      pdtc_pkg::ST_SUM:   state_d = pdtc_pkg::ST_ABS;
      pdtc_pkg::ST_ABS:   state_d = pdtc_pkg::ST_CLAMP;
      pdtc_pkg::ST_CLAMP: state_d = pdtc_pkg::ST_OUT;
      pdtc_pkg::ST_OUT:   if (out_load) state_d = pdtc_pkg::ST_IDLE;
      default:            state_d = pdtc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pdtc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // --------------------------------------------------------------------------
  // Shared multiplier and its operand select
  // --------------------------------------------------------------------------
  logic [MW-1:0]   mul_a;
  logic [MW-1:0]   mul_b;
  logic [2*MW-1:0] prod;

  logic [31:0] diff_mag_q;
  logic [32:0] pe_mag_q;
  logic [48:0] ve_mag_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      pdtc_pkg::ST_VEL: begin
        // |position difference| * loop rate
        mul_a = diff_mag_q;
        mul_b = {16'd0, loop_rate_hz_q};
      end
      pdtc_pkg::ST_VERR: begin
        mul_a = kp_gain_q;
        mul_b = pe_mag_q[31:0];
      end
      pdtc_pkg::ST_P_HI: begin
        mul_a = kp_gain_q;
        mul_b = {31'd0, pe_mag_q[32]};
      end
      pdtc_pkg::ST_P_END: begin
        mul_a = kd_gain_q;
        mul_b = ve_mag_q[31:0];
      end
      pdtc_pkg::ST_D_HI: begin
        mul_a = kd_gain_q;
        mul_b = {15'd0, ve_mag_q[48:32]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  pdtc_mul #(
    .Width (MW)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // --------------------------------------------------------------------------
  // Previous sample
  // --------------------------------------------------------------------------
  logic signed [31:0] prev_q;
  logic               primed_q;
  logic signed [31:0] prev_sel;

  // Before the first tick, treat the current sample as the previous one
  assign prev_sel = primed_q ? prev_q : measured_position_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= '0;
      primed_q <= 1'b0;
    end else if (in_accept) begin
      prev_q   <= measured_position_i;
      primed_q <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  logic signed [31:0] qd_q;
  logic signed [31:0] q_q;
  logic signed [23:0] vd_q;
  logic signed [32:0] diff_q;
  logic               diff_neg_q;
  logic signed [33:0] pe_q;
  logic               pe_neg_q;
  logic signed [49:0] ve_q;
  logic               ve_neg_q;
  logic [63:0]        acc_q;
  logic [61:0]        tmag_q;
  logic signed [63:0] sum_q;
  logic [62:0]        u_mag_q;
  logic               u_neg_q;
  logic [30:0]        c_mag_q;
  logic               c_neg_q;
  logic               sat_q;

  logic signed [49:0] vel_meas;
  logic signed [63:0] tmag_s;
  logic [30:0]        lim;
  logic [15:0]        rounded;

  assign vel_meas = $signed({2'b00, prod[47:0]});
  assign tmag_s   = $signed({2'b00, tmag_q});
  assign lim      = {max_torque_q, 16'd0};
  assign rounded  = 16'(({1'b0, c_mag_q} + 32'h0000_8000) >> 16);

  always_ff @(posedge clk_i) begin
    case (state_q)
      pdtc_pkg::ST_IDLE: begin
        if (in_accept) begin
          qd_q   <= desired_position_i;
          q_q    <= measured_position_i;
          vd_q   <= desired_velocity_i;
          diff_q <= 33'(measured_position_i) - 33'(prev_sel);
        end
      end
      pdtc_pkg::ST_DIFF: begin
        pe_q       <= 34'(qd_q) + 34'(zero_offset_q) - 34'(q_q);
        diff_neg_q <= diff_q[32];
        diff_mag_q <= diff_q[32] ? 32'(-diff_q) : diff_q[31:0];
      end
      pdtc_pkg::ST_VEL: begin
        pe_neg_q <= pe_q[33];
        pe_mag_q <= pe_q[33] ? 33'(-pe_q) : pe_q[32:0];
      end
      pdtc_pkg::ST_VERR: begin
        // velocity error = desired - signed measured velocity
        ve_q <= diff_neg_q ? (50'(vd_q) + vel_meas) : (50'(vd_q) - vel_meas);
      end
      pdtc_pkg::ST_P_HI: begin
        acc_q    <= prod;
        ve_neg_q <= ve_q[49];
        ve_mag_q <= ve_q[49] ? 49'(-ve_q) : ve_q[48:0];
      end
      pdtc_pkg::ST_P_END: begin
        tmag_q <= sat_term(acc_q, prod);
      end
      pdtc_pkg::ST_D_HI: begin
        sum_q <= pe_neg_q ? -tmag_s : tmag_s;
        acc_q <= prod;
      end
      pdtc_pkg::ST_D_END: begin
        tmag_q <= sat_term(acc_q, prod);
      end
      pdtc_pkg::ST_SUM: begin
        sum_q <= ve_neg_q ? (sum_q - tmag_s) : (sum_q + tmag_s);
      end
      pdtc_pkg::ST_ABS: begin
        u_neg_q <= sum_q[63] ^ invert_sign_q;
        u_mag_q <= sum_q[63] ? 63'(-sum_q) : sum_q[62:0];
      end
      pdtc_pkg::ST_CLAMP: begin
        c_neg_q <= u_neg_q;
        if (u_mag_q > {32'd0, lim}) begin
          c_mag_q <= lim;
          sat_q   <= 1'b1;
        end else begin
          c_mag_q <= u_mag_q[30:0];
          sat_q   <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic               out_valid_q;
  logic signed [15:0] torque_q;
  logic               saturated_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      torque_q    <= c_neg_q ? -$signed(rounded) : $signed(rounded);
      saturated_q <= sat_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign torque_command_o = torque_q;
  assign saturated_o      = saturated_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  logic signed [15:0] max_s;
  assign max_s = $signed({1'b0, max_torque_q});

  // A clamped command sits exactly on the limit
  a_sat_on_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> (torque_command_o == max_s) || (torque_command_o == -max_s))
    else $error("clamped command is not at the torque limit");

  // An unclamped command never exceeds the limit
  a_within_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (torque_command_o <= max_s) && (torque_command_o >= -max_s))
    else $error("torque command exceeds the limit");

  // Each accepted tick becomes the previous sample of the next one
  a_prev_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> primed_q && (prev_q == $past(measured_position_i)))
    else $error("previous sample not updated on accept");

  // A blocked result keeps the sequencer waiting with its result pending
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pdtc_pkg::ST_OUT) && out_valid_o && !out_ready_i
      |=> (state_q == pdtc_pkg::ST_OUT) && out_valid_o)
    else $error("result loaded over a pending word");

endmodule : pd_position_torque_controller
`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the PD position-to-torque controller
// Drives servo ticks and register writes over valid/ready channels, predicts
// every torque word with a bit-exact Q16.16 model kept in the bench, and
// compares each accepted output word field by field against that prediction.
// ----------------------------------------------------------------------------
module tb_top;

  // Generous ceiling for a run of ~520 ticks
  localparam int unsigned CYCLE_LIMIT   = 400000;
  // Settle time at the end of the run, after the last word is out
  localparam int unsigned SETTLE_CYCLES = 24;
  // Magnitude ceiling of each gain product, Q16.16
  localparam logic [63:0] TERM_MAX      = 64'h3FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic signed [15:0] torque;
    logic               sat;
  } torque_word_t;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT ports. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic                                clk               = 1'b0;
  logic                                rst_n             = 1'b0;
  logic                                cfg_valid         = 1'b0;
  logic                                cfg_ready;
  logic [pdtc_pkg::CFG_IDX_W-1:0]      cfg_index         = '0;
  logic [pdtc_pkg::CFG_DATA_W-1:0]     cfg_data          = '0;
  logic                                in_valid          = 1'b0;
  logic                                in_ready;
  logic signed [31:0]                  desired_position  = '0;
  logic signed [23:0]                  desired_velocity  = '0;
  logic signed [31:0]                  measured_position = '0;
  logic                                out_valid;
  logic                                out_ready         = 1'b0;
  logic signed [15:0]                  torque_command;
  logic                                saturated;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  pd_position_torque_controller dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .desired_position_i  (desired_position),
    .desired_velocity_i  (desired_velocity),
    .measured_position_i (measured_position),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .torque_command_o    (torque_command),
    .saturated_o         (saturated)
  );

  // --------------------------------------------------------------------------
  // Bench copy of the controller: register file and previous-sample state.
  // Start from the reset values; track every register write as it lands.
  // --------------------------------------------------------------------------
  logic [31:0]        gain_kp       = pdtc_pkg::KP_GAIN_RESET;
  logic [31:0]        gain_kd       = pdtc_pkg::KD_GAIN_RESET;
  logic [15:0]        rate_hz       = pdtc_pkg::LOOP_RATE_HZ_RESET;
  logic [14:0]        torque_limit  = pdtc_pkg::MAX_TORQUE_RESET;
  logic               invert_cmd    = 1'b0;
  logic signed [31:0] offset_counts = '0;
  logic signed [31:0] last_position = '0;
  logic               last_valid    = 1'b0;

  // Torque words predicted but not yet seen on the output, oldest first
  torque_word_t pending_cmds[$];

  int unsigned mismatches    = 0;
  int unsigned results_seen  = 0;
  int unsigned clamped_seen  = 0;
  int unsigned ticks_sent    = 0;
  int unsigned settings_used = 0;
  int unsigned cycles        = 0;
  // Set to run a stretch with neither side idling
  logic        no_idle       = 1'b0;

  // Gain times error, magnitude clamped to TERM_MAX. |err| < 2^51, so the
  // 96-bit product is exact and the clamp can be decided on it directly.
  function automatic longint gain_product(input logic [31:0] gain, input longint err);
    logic [63:0] mag;
    logic [95:0] prod;
    mag  = (err < 0) ? -err : err;
    prod = mag * gain;
    if (prod > TERM_MAX) prod = TERM_MAX;
    return (err < 0) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  // Expected torque word for one tick under the current registers and state
  function automatic torque_word_t predict_torque(input logic signed [31:0] qd,
                                                  input logic signed [23:0] vd,
                                                  input logic signed [31:0] q);
    longint prev, pos_err, vel_err, cmd, lim, mag, rounded;
    torque_word_t word;
    // First tick after reset: previous sample equals the current one
    prev    = last_valid ? longint'(last_position) : longint'(q);
    pos_err = longint'(qd) + longint'(offset_counts) - longint'(q);
    vel_err = longint'(vd) - (longint'(q) - prev) * longint'(rate_hz);
    cmd     = gain_product(gain_kp, pos_err) + gain_product(gain_kd, vel_err);
    if (invert_cmd) cmd = -cmd;
    lim      = longint'(torque_limit) * 65536;
    word.sat = 1'b0;
    // Hitting the limit exactly is not a clamp
    if (cmd > lim) begin
      cmd      = lim;
      word.sat = 1'b1;
    end else if (cmd < -lim) begin
      cmd      = -lim;
      word.sat = 1'b1;
    end
    // Round half away from zero, drop the 16 fraction bits
    mag         = (cmd < 0) ? -cmd : cmd;
    rounded     = (mag + 32768) >> 16;
    cmd         = (cmd < 0) ? -rounded : rounded;
    word.torque = cmd[15:0];
    return word;
  endfunction

  // Mostly no idle, some short gaps, a few long ones
  function automatic int unsigned idle_len();
    int unsigned roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 19);
    if (roll < 12) return 0;
    if (roll < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic longint pick_signed(input longint span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // --------------------------------------------------------------------------
  // Output side: pop the oldest prediction for each accepted word and compare
  // field by field. Stall ready at random in the same process.
  // --------------------------------------------------------------------------
  int unsigned stall_left = 0;

  always @(posedge clk) begin
    torque_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_cmds.size() == 0) begin
        flag_mismatch($sformatf("unexpected word: torque %0d sat %0b",
                                torque_command, saturated));
      end else begin
        want = pending_cmds.pop_front();
        results_seen++;
        if (want.sat) clamped_seen++;
        if (torque_command !== want.torque)
          flag_mismatch($sformatf("word %0d: torque %0d, want %0d",
                                  results_seen, torque_command, want.torque));
        if (saturated !== want.sat)
          flag_mismatch($sformatf("word %0d: saturated %0b, want %0b",
                                  results_seen, saturated, want.sat));
      end
    end
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      stall_left = idle_len();
    end
  end

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words outstanding",
               cycles, pending_cmds.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Input side. Called at a rising edge; returns at a rising edge. Valid is
  // only dropped when a gap follows, so back-to-back words keep it high.
  // --------------------------------------------------------------------------
  task automatic send_tick(input logic signed [31:0] qd,
                           input logic signed [23:0] vd,
                           input logic signed [31:0] q);
    int unsigned gap;
    in_valid          <= 1'b1;
    desired_position  <= qd;
    desired_velocity  <= vd;
    measured_position <= q;
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
    // Word taken: predict it, then advance the previous-sample state
    pending_cmds.push_back(predict_torque(qd, vd, q));
    last_position = q;
    last_valid    = 1'b1;
    ticks_sent++;
    gap = idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold input valid low and wait until every predicted word has come out.
  // Each tick yields exactly one word, so an empty queue means an idle block.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_cmds.size() != 0);
  endtask

  // One register write; valid stays high for a following write
  task automatic write_reg(input logic [pdtc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pdtc_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!(cfg_valid && cfg_ready)) @(posedge clk);
    case (idx)
      pdtc_pkg::CFG_KP_GAIN:      gain_kp       = value;
      pdtc_pkg::CFG_KD_GAIN:      gain_kd       = value;
      pdtc_pkg::CFG_LOOP_RATE_HZ: rate_hz       = value[15:0];
      pdtc_pkg::CFG_MAX_TORQUE:   torque_limit  = value[14:0];
      pdtc_pkg::CFG_INVERT_SIGN:  invert_cmd    = value[0];
      pdtc_pkg::CFG_ZERO_OFFSET:  offset_counts = value;
      default: ;
    endcase
  endtask

  // Drain, then rewrite the whole register file
  task automatic apply_setting(input logic [31:0] kp, input logic [31:0] kd,
                               input logic [15:0] rate, input logic [14:0] limit,
                               input logic inv, input logic signed [31:0] off);
    wait_idle();
    write_reg(pdtc_pkg::CFG_KP_GAIN, kp);
    write_reg(pdtc_pkg::CFG_KD_GAIN, kd);
    write_reg(pdtc_pkg::CFG_LOOP_RATE_HZ, {16'd0, rate});
    write_reg(pdtc_pkg::CFG_MAX_TORQUE, {17'd0, limit});
    write_reg(pdtc_pkg::CFG_INVERT_SIGN, {31'd0, inv});
    write_reg(pdtc_pkg::CFG_ZERO_OFFSET, off);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // First tick after reset sees zero measured velocity even though the
  // measured position is far from zero; the next tick sees a real difference.
  task automatic test_first_tick();
    settings_used++;
    send_tick(32'sd0, 24'sd0, 32'sd123456);
    send_tick(32'sd123457, 24'sd200, 32'sd123457);
    send_tick(32'sd0, 24'sd0, 32'sd0);
  endtask

  // Field extremes under reset gains; the position jump spans the full 33 bits
  task automatic test_field_extremes();
    send_tick(32'sh7FFF_FFFF, 24'sh7F_FFFF, 32'sh8000_0000);
    send_tick(32'sh8000_0000, 24'sh80_0000, 32'sh7FFF_FFFF);
    send_tick(-32'sd1, -24'sd1, -32'sd1);
  endtask

  // Half-count errors at kp = 0.5 exercise rounding away from zero. Loop rate
  // zero must kill the measured velocity despite the large position jumps.
  task automatic test_rounding();
    apply_setting(32'h0000_8000, 32'h0001_0000, 16'd0, 15'd32767, 1'b0, 32'sd0);
    send_tick(32'sd1001, 24'sd0, 32'sd1000);
    send_tick(-32'sd5000001, 24'sd0, -32'sd5000000);
    send_tick(32'sd2000000003, 24'sd0, 32'sd2000000000);
    send_tick(-32'sd3, 24'sd0, 32'sd0);
  endtask

  // Unity kp, limit 100: equality is not flagged, one count beyond is.
  // Then inverted output, then a zero limit.
  task automatic test_clamp_edges();
    apply_setting(32'h0001_0000, 32'd0, 16'd200, 15'd100, 1'b0, 32'sd0);
    send_tick(32'sd600, 24'sd0, 32'sd500);
    send_tick(32'sd601, 24'sd0, 32'sd500);
    send_tick(32'sd400, 24'sd0, 32'sd500);
    send_tick(32'sd399, 24'sd0, 32'sd500);
    apply_setting(32'h0001_0000, 32'd0, 16'd200, 15'd100, 1'b1, 32'sd0);
    send_tick(32'sd601, 24'sd0, 32'sd500);
    send_tick(32'sd460, 24'sd0, 32'sd500);
    apply_setting(32'h0001_0000, 32'd0, 16'd200, 15'd0, 1'b1, 32'sd0);
    send_tick(32'sd501, 24'sd0, 32'sd500);
    send_tick(32'sd500, 24'sd0, 32'sd500);
  endtask

  // Full-scale gains, rate, offsets: first two ticks saturate both terms
  task automatic test_huge_terms();
    apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 15'd32767, 1'b0,
                  32'sh7FFF_FFFF);
    send_tick(32'sh7FFF_FFFF, 24'sh80_0000, 32'sh8000_0000);
    send_tick(32'sh8000_0000, 24'sh7F_FFFF, 32'sh7FFF_FFFF);
    apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 15'd32767, 1'b1,
                  32'sh8000_0000);
    send_tick(32'sh8000_0000, 24'sh7F_FFFF, 32'sh7FFF_FFFF);
  endtask

  // --------------------------------------------------------------------------
  // Random tests
  // --------------------------------------------------------------------------

  // Raw noise: every bit of every field and register at random
  task automatic test_random_noise();
    repeat (4) begin
      apply_setting($urandom, $urandom, 16'($urandom_range(0, 65535)),
                    15'($urandom_range(0, 32767)), 1'($urandom_range(0, 1)), $urandom);
      repeat (25) send_tick($urandom, 24'($urandom), $urandom);
    end
  endtask

  // A slowly moving target tracked by an encoder with a small, decaying
  // error, scaled so many commands stay inside the limit. An occasional
  // encoder jump breaks the sequence.
  task automatic run_trajectory(input int unsigned count);
    longint target, stride, err, vd_v, q_v, err_span, vel_span;
    target   = pick_signed(100000);
    err      = 0;
    err_span = longint'(torque_limit) * 65536 / (longint'(gain_kp) + 1) + 1;
    vel_span = longint'(torque_limit) * 65536 / (longint'(gain_kd) + 1) + 1;
    if (err_span > 100000) err_span = 100000;
    if (vel_span > 100000) vel_span = 100000;
    repeat (count) begin
      stride = pick_signed(40);
      target += stride;
      err    = err / 2 + pick_signed(err_span / 2 + 1);
      if ($urandom_range(0, 19) == 0) err += pick_signed(1000000);
      vd_v = stride * longint'(rate_hz) + pick_signed(vel_span);
      if (vd_v > 8388607) vd_v = 8388607;
      if (vd_v < -8388608) vd_v = -8388608;
      q_v = target + longint'(offset_counts) - err;
      send_tick(target[31:0], vd_v[23:0], q_v[31:0]);
    end
  endtask

  task automatic apply_moderate_setting(input logic [15:0] rate, input logic inv);
    apply_setting($urandom_range(32'h800, 32'h4_0000), $urandom_range(32'h100, 32'h2_0000),
                  rate, 15'($urandom_range(50, 32767)), inv, 32'(pick_signed(1000000)));
  endtask

  task automatic test_trajectories();
    apply_setting(pdtc_pkg::KP_GAIN_RESET, pdtc_pkg::KD_GAIN_RESET,
                  pdtc_pkg::LOOP_RATE_HZ_RESET, pdtc_pkg::MAX_TORQUE_RESET,
                  1'b0, 32'sd0);
    run_trajectory(100);
    apply_moderate_setting(16'($urandom_range(1, 2000)), 1'($urandom_range(0, 1)));
    run_trajectory(100);
    // Same shape with neither side idling
    apply_moderate_setting(16'($urandom_range(1, 2000)), 1'($urandom_range(0, 1)));
    no_idle = 1'b1;
    run_trajectory(100);
    no_idle = 1'b0;
    apply_moderate_setting(16'd1, 1'b1);
    run_trajectory(100);
  endtask

  // --------------------------------------------------------------------------
  // Sequence: reset once, run each test in turn, drain, report
  // --------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_first_tick();
    test_field_extremes();
    test_rounding();
    test_clamp_edges();
    test_huge_terms();
    test_random_noise();
    test_trajectories();
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Drove %0d servo ticks under %0d register settings in %0d cycles.",
             ticks_sent, settings_used, cycles);
    $display("Checked %0d torque words, %0d of them clamped; %0d mismatches.",
             results_seen, clamped_seen, mismatches);
    if (mismatches == 0 && pending_cmds.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
